// ===== hdl/qfcd_pkg.sv =====
// Shared constants, status codes and controller/datapath interface types
// for the quota job queue. No dependencies.
package qfcd_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int REQUESTERS  = 64;

   localparam int OP_W     = 1;
   localparam int RQ_W     = 6;
   localparam int JOB_W    = 16;
   localparam int PAGES_W  = 12;
   localparam int CREDIT_W = 16;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 4;
   localparam int LIMIT_W  = 4;

   localparam int QAW    = $clog2(QUEUE_DEPTH);
   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_AW = $clog2(REQUESTERS);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

   localparam logic [OP_W-1:0] OP_SUBMIT = 1'b0;
   localparam logic [OP_W-1:0] OP_DRAIN  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUOTA_REJECT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL_REJECT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SERVED       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTIED      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_STOPPED      = 3'd5;

   typedef struct packed {
      logic [RQ_W-1:0]    requester;
      logic [JOB_W-1:0]   job;
      logic [PAGES_W-1:0] pages;
   } job_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // capture the input beat
      logic cnt_rd_head;  // count lookup for the head job's owner
      logic submit;       // decide, commit and emit the submit result
      logic pop;          // pop head job and emit a served result
      logic emit_final;   // emit the closing drain result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic item_op;
      logic occ_zero;
      logic head_fits;
      logic out_free;
   } sts_type;

endpackage

// ===== hdl/qfcd_datapath.sv =====
// Datapath of the quota job queue: job store, per-requester counts,
// drain credit, limit register and result register. Uses qfcd_pkg.
module qfcd_datapath import qfcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [RQ_W-1:0]      req_requester_id,
   input  logic [JOB_W-1:0]     req_job_id,
   input  logic [PAGES_W-1:0]   req_job_pages,
   input  logic [CREDIT_W-1:0]  req_credit_available,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LIMIT_W-1:0]   csr_per_requester_limit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [JOB_W-1:0]     rsp_served_job_id,
   output logic [RQ_W-1:0]      rsp_served_requester,
   output logic [PAGES_W-1:0]   rsp_served_pages,
   output logic [CREDIT_W-1:0]  rsp_credit_left,
   output logic [COUNT_W-1:0]   rsp_requester_count,
   output logic                 rsp_last_of_run,
   input  cmd_type              cmd,
   output sts_type              sts
);

   localparam logic [RQ_W:0]    REQ_BOUND = (RQ_W + 1)'(REQUESTERS);
   localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(QUEUE_DEPTH);
   localparam logic [QAW-1:0]   IDX_LAST  = QAW'(QUEUE_DEPTH - 1);

   logic [OP_W-1:0]     item_op_ff;
   logic [RQ_W-1:0]     item_rq_ff;
   logic [JOB_W-1:0]    item_job_ff;
   logic [PAGES_W-1:0]  item_pages_ff;
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [QAW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;

   job_entry_type       job_mem_ff [QUEUE_DEPTH];
   logic [COUNT_W-1:0]  cnt_mem_ff [REQUESTERS];
   logic [REQUESTERS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [COUNT_W-1:0]  cnt_rd_ff;
   logic                cnt_rd_vld_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [JOB_W-1:0]    rsp_job_ff;
   logic [RQ_W-1:0]     rsp_rq_ff;
   logic [PAGES_W-1:0]  rsp_pages_ff;
   logic [CREDIT_W-1:0] rsp_credit_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;

   job_entry_type       head_entry;
   logic [COUNT_W-1:0]  cnt_cur;
   logic                rq_in_range;
   logic                quota_hit;
   logic                q_full;
   logic                sub_accept;
   logic [CREDIT_W-1:0] credit_after;
   logic [REQ_AW-1:0]   cnt_rd_addr;
   logic [REQ_AW-1:0]   cnt_wr_addr;
   logic                cnt_wr_en;
   logic [COUNT_W-1:0]  cnt_wr_data;
   logic                emit_any;

   always_comb begin
      head_entry   = job_mem_ff[head_ff];
      cnt_cur      = cnt_rd_vld_ff ? cnt_rd_ff : '0;
      rq_in_range  = {1'b0, item_rq_ff} < REQ_BOUND;
      quota_hit    = !rq_in_range || (cnt_cur >= limit_ff);
      q_full       = occ_ff >= OCC_FULL;
      sub_accept   = cmd.submit && !quota_hit && !q_full;
      credit_after = credit_ff - CREDIT_W'(head_entry.pages);
      emit_any     = cmd.submit || cmd.pop || cmd.emit_final;

      cnt_rd_addr = cmd.cnt_rd_head ? head_entry.requester[REQ_AW-1:0]
                                    : item_rq_ff[REQ_AW-1:0];
      cnt_wr_en   = sub_accept || cmd.pop;
      cnt_wr_addr = cmd.pop ? head_entry.requester[REQ_AW-1:0]
                            : item_rq_ff[REQ_AW-1:0];
      // drop the owner's count on pop, never below zero
      cnt_wr_data = cmd.pop ? (cnt_cur - COUNT_W'(cnt_cur != '0))
                            : (cnt_cur + COUNT_W'(1));
   end

   always_comb begin
      limit_in   = (csr_valid && csr_ready) ? csr_per_requester_limit : limit_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      occ_in     = occ_ff;
      cnt_vld_in = cnt_vld_ff;
      credit_in  = credit_ff;
      if (cmd.load) begin
         credit_in = req_credit_available;
      end
      if (sub_accept) begin
         tail_in = (tail_ff == IDX_LAST) ? '0 : tail_ff + QAW'(1);
         occ_in  = occ_ff + OCC_W'(1);
         cnt_vld_in[cnt_wr_addr] = 1'b1;
      end
      if (cmd.pop) begin
         head_in   = (head_ff == IDX_LAST) ? '0 : head_ff + QAW'(1);
         occ_in    = occ_ff - OCC_W'(1);
         credit_in = credit_after;
      end
      if (emit_any) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         cnt_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         cnt_vld_ff   <= cnt_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      credit_ff <= credit_in;
      if (cmd.load) begin
         item_op_ff    <= req_opcode;
         item_rq_ff    <= req_requester_id;
         item_job_ff   <= req_job_id;
         item_pages_ff <= req_job_pages;
      end
      if (sub_accept) begin
         job_mem_ff[tail_ff] <= '{requester: item_rq_ff, job: item_job_ff,
                                  pages: item_pages_ff};
      end
   end

   // count memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cnt_wr_en) begin
         cnt_mem_ff[cnt_wr_addr] <= cnt_wr_data;
      end
      cnt_rd_ff     <= cnt_mem_ff[cnt_rd_addr];
      cnt_rd_vld_ff <= cnt_vld_ff[cnt_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.submit) begin
         rsp_status_ff <= quota_hit ? ST_QUOTA_REJECT :
                          q_full    ? ST_FULL_REJECT  : ST_ACCEPTED;
         rsp_job_ff    <= '0;
         rsp_rq_ff     <= '0;
         rsp_pages_ff  <= '0;
         rsp_credit_ff <= '0;
         rsp_count_ff  <= rq_in_range ? cnt_cur : '0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.pop) begin
         rsp_status_ff <= ST_SERVED;
         rsp_job_ff    <= head_entry.job;
         rsp_rq_ff     <= head_entry.requester;
         rsp_pages_ff  <= head_entry.pages;
         rsp_credit_ff <= credit_after;
         rsp_count_ff  <= '0;
         rsp_last_ff   <= 1'b0;
      end else if (cmd.emit_final) begin
         rsp_status_ff <= (occ_ff == '0) ? ST_EMPTIED : ST_STOPPED;
         rsp_job_ff    <= '0;
         rsp_rq_ff     <= '0;
         rsp_pages_ff  <= '0;
         rsp_credit_ff <= credit_ff;
         rsp_count_ff  <= '0;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_served_job_id    = rsp_job_ff;
   assign rsp_served_requester = rsp_rq_ff;
   assign rsp_served_pages     = rsp_pages_ff;
   assign rsp_credit_left      = rsp_credit_ff;
   assign rsp_requester_count  = rsp_count_ff;
   assign rsp_last_of_run      = rsp_last_ff;

   assign sts.item_op   = item_op_ff;
   assign sts.occ_zero  = occ_ff == '0;
   assign sts.head_fits = {{(CREDIT_W - PAGES_W){1'b0}}, head_entry.pages} <= credit_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("occupancy above queue depth");

   a_pop_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (occ_ff != '0) && sts.head_fits)
      else $error("pop of empty queue or of a job the credit does not cover");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      sub_accept |=> occ_ff == $past(occ_ff) + OCC_W'(1))
      else $error("accepted submit did not grow the queue");

endmodule

// ===== hdl/qfcd_ctrl.sv =====
// Sequencer of the quota job queue: steps submits and drains and issues
// datapath commands. Uses qfcd_pkg.
module qfcd_ctrl import qfcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SUB_RD = 3'd1;
   localparam logic [2:0] S_SUB_DO = 3'd2;
   localparam logic [2:0] S_DR_RD  = 3'd3;
   localparam logic [2:0] S_DR_POP = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SUB_RD;
            end
         end
         S_SUB_RD: begin
            // count lookup for the submitter runs this cycle
            state_in = (sts.item_op == OP_DRAIN) ? S_DR_RD : S_SUB_DO;
         end
         S_SUB_DO: begin
            if (sts.out_free) begin
               cmd.submit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DR_RD: begin
            cmd.cnt_rd_head = 1'b1;
            if (sts.occ_zero || !sts.head_fits) begin
               if (sts.out_free) begin
                  cmd.emit_final = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               state_in = S_DR_POP;
            end
         end
         S_DR_POP: begin
            // hold the head job until the result register frees up; keep
            // the owner's count in the read register meanwhile
            cmd.cnt_rd_head = 1'b1;
            if (sts.out_free) begin
               cmd.pop  = 1'b1;
               state_in = S_DR_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.submit || cmd.pop || cmd.emit_final) |-> sts.out_free)
      else $error("result emitted while result register occupied");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat taken while an item is in progress");

   a_pop_then_look: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> state_ff == S_DR_RD)
      else $error("drain did not return to head check after a pop");

endmodule

// ===== hdl/quota_fifo_with_credit_drain_unit.sv =====
// Top level of the quota job queue: sequencer plus datapath.
// Depends on qfcd_pkg, qfcd_ctrl and qfcd_datapath.
//
// Submit: the beat is captured, the submitter's count read, then the result
// registered; one item in flight at a time, the next beat taken in idle.
// Drain: a head check then a pop per served job, then the final result,
// after which the block returns to idle for the next beat; each result
// also waits on a free result register.
// Synchronous reset empties the queue, zeroes all counts and sets the
// limit to 3; no clearing pass, the block takes a beat right after reset.
module quota_fifo_with_credit_drain_unit import qfcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [RQ_W-1:0]      req_requester_id,
   input  logic [JOB_W-1:0]     req_job_id,
   input  logic [PAGES_W-1:0]   req_job_pages,
   input  logic [CREDIT_W-1:0]  req_credit_available,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LIMIT_W-1:0]   csr_per_requester_limit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [JOB_W-1:0]     rsp_served_job_id,
   output logic [RQ_W-1:0]      rsp_served_requester,
   output logic [PAGES_W-1:0]   rsp_served_pages,
   output logic [CREDIT_W-1:0]  rsp_credit_left,
   output logic [COUNT_W-1:0]   rsp_requester_count,
   output logic                 rsp_last_of_run
);

   cmd_type cmd;
   sts_type sts;

   qfcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   qfcd_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .req_opcode              (req_opcode),
      .req_requester_id        (req_requester_id),
      .req_job_id              (req_job_id),
      .req_job_pages           (req_job_pages),
      .req_credit_available    (req_credit_available),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_per_requester_limit (csr_per_requester_limit),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_status              (rsp_status),
      .rsp_served_job_id       (rsp_served_job_id),
      .rsp_served_requester    (rsp_served_requester),
      .rsp_served_pages        (rsp_served_pages),
      .rsp_credit_left         (rsp_credit_left),
      .rsp_requester_count     (rsp_requester_count),
      .rsp_last_of_run         (rsp_last_of_run),
      .cmd                     (cmd),
      .sts                     (sts)
   );

endmodule
